// ===== sv/isbnv_pkg.sv =====
// ============================================================================
// isbnv_pkg
// Shared types, character codes and checksum helpers for the ISBN-10 checker
// ============================================================================
package isbnv_pkg;

    // character codes
    localparam logic [7:0] CH_DASH = 8'd45;
    localparam logic [7:0] CH_X    = 8'd88;
    localparam logic [7:0] CH_ZERO = 8'd48;
    localparam logic [7:0] CH_NINE = 8'd57;

    // limits of the string format
    localparam logic [3:0] POS_LIMIT    = 4'd13;
    localparam logic [3:0] SYMBOL_COUNT = 4'd10;
    localparam logic [3:0] SYMBOL_CAP   = 4'd11;
    localparam logic [2:0] DASH_COUNT   = 3'd3;
    localparam logic [2:0] DASH_CAP     = 3'd4;
    localparam logic [3:0] DASH0_MIN    = 4'd1;
    localparam logic [3:0] DASH0_MAX    = 4'd5;
    localparam logic [3:0] GAP_MIN      = 4'd2;
    localparam logic [3:0] GAP1_MAX     = 4'd8;
    localparam logic [3:0] GAP2_MAX     = 4'd7;
    localparam logic [3:0] X_VALUE      = 4'd10;
    localparam logic [3:0] MOD_BASE     = 4'd11;

    // one accepted character with its end-of-string mark
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } isbnv_char_t;

    // value below 121 reduced modulo 11: reciprocal 187/2048 gives the quotient
    function automatic logic [3:0] mod11(input logic [6:0] x);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [6:0]  r;
        prod = 15'(x) * 15'd187;
        q    = prod[14:11];
        r    = x - (7'(q) * 7'(MOD_BASE));
        return r[3:0];
    endfunction

endpackage

// ===== sv/isbnv_tracker.sv =====
// ============================================================================
// isbnv_tracker
// Per-string state: position, dash positions, symbol count and mod-11 residue
// ============================================================================
module isbnv_tracker
    import isbnv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  isbnv_char_t ch,
    output logic        verdict
);

    logic [3:0] pos_reg,      pos_next;
    logic       overlong_reg, overlong_next;
    logic       bad_reg,      bad_next;
    logic [2:0] dcnt_reg,     dcnt_next;
    logic [3:0] dpos_reg  [3];
    logic [3:0] dpos_next [3];
    logic [3:0] scnt_reg,     scnt_next;
    logic [3:0] res_reg,      res_next;

    logic       is_digit;
    logic       is_sym;
    logic [3:0] sym_val;
    logic [3:0] weight;
    logic [6:0] wsum;
    logic       in_range;
    logic [3:0] gap1;
    logic [3:0] gap2;

    // character classes and weighted term
    assign is_digit = (ch.code >= CH_ZERO) && (ch.code <= CH_NINE);
    assign is_sym   = is_digit || ((ch.code == CH_X) && ch.last);
    assign sym_val  = is_digit ? ch.code[3:0] : X_VALUE;
    assign weight   = SYMBOL_COUNT - scnt_reg;
    assign wsum     = 7'(res_reg) + (7'(sym_val) * 7'(weight));
    assign in_range = !overlong_reg && (pos_reg < POS_LIMIT);

    // next state for one character
    always_comb
    begin
        pos_next      = pos_reg;
        overlong_next = overlong_reg;
        bad_next      = bad_reg;
        dcnt_next     = dcnt_reg;
        dpos_next     = dpos_reg;
        scnt_next     = scnt_reg;
        res_next      = res_reg;
        if (!in_range)
        begin
            overlong_next = 1'b1;
        end
        else
        begin
            if (is_sym)
            begin
                if (scnt_reg < SYMBOL_COUNT)
                begin
                    res_next = mod11(wsum);
                end
                if (scnt_reg < SYMBOL_CAP)
                begin
                    scnt_next = scnt_reg + 4'd1;
                end
            end
            else if (ch.code == CH_DASH)
            begin
                if (dcnt_reg < DASH_COUNT)
                begin
                    dpos_next[dcnt_reg[1:0]] = pos_reg;
                end
                if (dcnt_reg < DASH_CAP)
                begin
                    dcnt_next = dcnt_reg + 3'd1;
                end
            end
            else
            begin
                bad_next = 1'b1;
            end
            pos_next = pos_reg + 4'd1;
        end
    end

    // judgement on the updated state, last index is the current position
    assign gap1 = dpos_next[1] - dpos_next[0];
    assign gap2 = dpos_next[2] - dpos_next[1];

    always_comb
    begin
        verdict = !bad_next && !overlong_next && (dcnt_next == DASH_COUNT)
                  && (dpos_next[0] >= DASH0_MIN) && (dpos_next[0] <= DASH0_MAX)
                  && (dpos_next[1] > dpos_next[0]) && (dpos_next[2] > dpos_next[1])
                  && (gap1 >= GAP_MIN) && (gap1 <= GAP1_MAX)
                  && (gap2 >= GAP_MIN) && (gap2 <= GAP2_MAX)
                  && ((5'(dpos_next[2]) + 5'd1) == 5'(pos_reg))
                  && (scnt_next == SYMBOL_COUNT)
                  && (res_next == 4'd0);
    end

    // state registers, cleared after the last character of each string
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            overlong_reg <= 1'b0;
            bad_reg      <= 1'b0;
            dcnt_reg     <= '0;
            dpos_reg     <= '{default: '0};
            scnt_reg     <= '0;
            res_reg      <= '0;
        end
        else if (step)
        begin
            if (ch.last)
            begin
                pos_reg      <= '0;
                overlong_reg <= 1'b0;
                bad_reg      <= 1'b0;
                dcnt_reg     <= '0;
                dpos_reg     <= '{default: '0};
                scnt_reg     <= '0;
                res_reg      <= '0;
            end
            else
            begin
                pos_reg      <= pos_next;
                overlong_reg <= overlong_next;
                bad_reg      <= bad_next;
                dcnt_reg     <= dcnt_next;
                dpos_reg     <= dpos_next;
                scnt_reg     <= scnt_next;
                res_reg      <= res_next;
            end
        end
    end

endmodule

// ===== sv/isbn10_hyphenated_validator_core.sv =====
// ============================================================================
// isbn10_hyphenated_validator_core
// Hyphenated ISBN-10 checker, one character per transfer, one result per string
// ============================================================================
//
//  channel | dir | signals                         | content
//  --------+-----+---------------------------------+------------------------------
//  s       | in  | s_tvalid s_tready s_tdata s_tlast | one character, tlast ends string
//  m       | out | m_tvalid m_tready m_tdata         | valid bit, one per string
//
// One character per cycle while no waiting result stalls a last character: an input
// register feeds the state update, and the verdict loads into an output register
// as the last character leaves the input register. Both registers lie between the
// last character's transfer and the verdict's transfer.
// Reset clears all string state and both stage valid bits.
// A waiting result only stalls a last character; other characters keep moving.
//
module isbn10_hyphenated_validator_core
    import isbnv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic       s_tlast,   // is_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] valid_res, [7:1] zero
);

    logic        in_valid_reg;
    isbnv_char_t in_char_reg;
    logic        out_valid_reg;
    logic        out_res_reg;
    logic        out_free;
    logic        advance;
    logic        verdict;

    // stage handshake
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_char_reg.last || out_free);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_char_reg.code <= s_tdata;
            in_char_reg.last <= s_tlast;
        end
    end

    // per-string state and judgement
    isbnv_tracker u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .ch      (in_char_reg),
        .verdict (verdict)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_char_reg.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_char_reg.last)
        begin
            out_res_reg <= verdict;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_res_reg};

endmodule
